// ===== design/battery_voltage_to_charge_percent_top_assert.svh =====
// ============================================================================
// Assertion macros for the battery charge estimator.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while reset is high.
// ============================================================================
`ifndef BATTERY_VOLTAGE_TO_CHARGE_PERCENT_TOP_ASSERT_SVH
`define BATTERY_VOLTAGE_TO_CHARGE_PERCENT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVCP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BVCP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bvcp_pkg.sv =====
// ============================================================================
// bvcp_pkg
// Curve tables, field widths and register indexes of the battery charge
// estimator.
// ============================================================================
`default_nettype none

package bvcp_pkg;

   localparam int MV_W    = 16;
   localparam int PCT_W   = 7;
   localparam int NTHR_W  = 10;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 1;

   // Segment arithmetic: offsets and spans stay below 256 mV, percent spans
   // stay at or below 10.
   localparam int OFF_W   = 8;
   localparam int SPANP_W = 4;
   localparam int PROD_W  = OFF_W + SPANP_W;
   localparam int SEG_W   = 4;
   localparam int CNT_W   = 4;

   localparam int CURVE_POINTS = 14;

   localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      16'd4200, 16'd4150, 16'd4100, 16'd4000, 16'd3950, 16'd3900, 16'd3850,
      16'd3800, 16'd3750, 16'd3700, 16'd3650, 16'd3500, 16'd3300, 16'd3200
   };

   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd100, 7'd95, 7'd90, 7'd80, 7'd75, 7'd70, 7'd60,
      7'd50,  7'd40, 7'd30, 7'd20, 7'd10, 7'd5,  7'd0
   };

   localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

   localparam logic [NTHR_W-1:0] NOTIFY_THR_RESET = 10'd50;
   localparam logic [MV_W-1:0]   CHARGE_THR_RESET = 16'd4150;

   localparam logic [CSR_IDX_W-1:0] CSR_NOTIFY_THR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_THR = 1'b1;

endpackage

`default_nettype wire

// ===== design/battery_voltage_to_charge_percent_top.sv =====
// ============================================================================
// battery_voltage_to_charge_percent_top
// LiPo charge estimator: maps a battery voltage in mV to a charge percentage
// on a 14-point discharge curve, and flags charging and large voltage steps.
// Usage: a request carries req_battery_mv on a valid/ready channel. The block
// takes one request at a time; req_ready is high only while it is idle. The
// response (voltage echo, percent, charging, notify) appears on rsp_* with
// rsp_valid after segment setup and the divider steps, and holds until taken.
// The restoring divider produces one quotient bit per cycle over the 12-bit
// product of offset and percent span. A stalled receiver simply holds the
// block in its output state. Reset (synchronous, active high) restores the
// thresholds (50 mV notify, 4150 mV charging) and forgets the stored voltage,
// so the first request after reset never notifies. Thresholds are written
// through csr_we/csr_index/csr_wdata; the user must write them only while
// the block is idle, which the block itself does not enforce.
// ============================================================================
`default_nettype none

module battery_voltage_to_charge_percent_top
   import bvcp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [MV_W-1:0]      req_battery_mv,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [MV_W-1:0]           rsp_voltage_out_mv,
   output logic [PCT_W-1:0]          rsp_charge_percent,
   output logic                      rsp_charging,
   output logic                      rsp_notify,

   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   // The sequencer walks each request through segment setup, the divider
   // iterations and finally the output hold state.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_OUT
   } state_type;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

   state_type            state_ff, state_in;
   logic [NTHR_W-1:0]    notify_thr_ff, notify_thr_in;
   logic [MV_W-1:0]      charge_thr_ff, charge_thr_in;
   logic [MV_W-1:0]      prev_mv_ff, prev_mv_in;
   logic                 primed_ff, primed_in;
   logic [MV_W-1:0]      volt_ff, volt_in;
   logic                 notify_ff, notify_in;
   logic                 charging_ff, charging_in;
   logic [PCT_W-1:0]     lo_pct_ff, lo_pct_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [OFF_W-1:0]     rem_ff, rem_in;
   logic [OFF_W-1:0]     div_ff, div_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PCT_W-1:0]     pct_ff, pct_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Segment lookup and the operands of the divide.
   logic [SEG_W-1:0]     seg_idx;
   logic [SEG_W-1:0]     seg_lo_idx;
   logic [MV_W-1:0]      seg_lo_mv;
   logic [OFF_W-1:0]     off_mv;
   logic [OFF_W-1:0]     span_mv;
   logic [SPANP_W-1:0]   span_pct;
   logic [PROD_W-1:0]    product;

   // Divider step and change detection.
   logic [OFF_W:0]       trial;
   logic                 trial_ge;
   logic [MV_W-1:0]      delta_mv;

   logic                 req_accept;
   logic                 rsp_accept;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid_ff && rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_voltage_out_mv = volt_ff;
   assign rsp_charge_percent = pct_ff;
   assign rsp_charging       = charging_ff;
   assign rsp_notify         = notify_ff;

   // The segment is the first one, from the top of the curve, whose lower
   // point lies at or below the voltage. The loop runs downward so the
   // smallest matching index is the one left standing.
   always_comb begin
      seg_idx = '0;
      for (int k = CURVE_POINTS - 2; k >= 0; k--) begin
         if (volt_ff >= CURVE_MV[k + 1]) begin
            seg_idx = SEG_W'(k);
         end
      end
   end

   assign seg_lo_idx = seg_idx + SEG_W'(1);
   assign seg_lo_mv  = CURVE_MV[seg_lo_idx];
   assign off_mv     = OFF_W'(volt_ff - seg_lo_mv);
   assign span_mv    = OFF_W'(CURVE_MV[seg_idx] - seg_lo_mv);
   assign span_pct   = SPANP_W'(CURVE_PCT[seg_idx] - CURVE_PCT[seg_lo_idx]);
   assign product    = PROD_W'(off_mv) * PROD_W'(span_pct);

   // One restoring step: bring down the next dividend bit and subtract the
   // span when it fits. The remainder always stays below the span.
   assign trial    = {rem_ff, quo_ff[PROD_W-1]};
   assign trial_ge = (trial >= {1'b0, div_ff});

   assign delta_mv = (req_battery_mv >= prev_mv_ff) ? (req_battery_mv - prev_mv_ff)
                                                    : (prev_mv_ff - req_battery_mv);

   always_comb begin
      state_in      = state_ff;
      notify_thr_in = notify_thr_ff;
      charge_thr_in = charge_thr_ff;
      prev_mv_in    = prev_mv_ff;
      primed_in     = primed_ff;
      volt_in       = volt_ff;
      notify_in     = notify_ff;
      charging_in   = charging_ff;
      lo_pct_in     = lo_pct_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      cnt_in        = cnt_ff;
      pct_in        = pct_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_NOTIFY_THR: notify_thr_in = csr_wdata[NTHR_W-1:0];
            CSR_CHARGE_THR: charge_thr_in = csr_wdata[MV_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // The flags only need the thresholds and the stored voltage,
               // so they are settled right at acceptance.
               volt_in     = req_battery_mv;
               charging_in = (req_battery_mv > charge_thr_ff);
               notify_in   = primed_ff && (delta_mv > MV_W'(notify_thr_ff));
               prev_mv_in  = req_battery_mv;
               primed_in   = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            rem_in = '0;
            cnt_in = '0;
            if (volt_ff >= CURVE_MV[0]) begin
               lo_pct_in = PCT_FULL;
               quo_in    = '0;
               div_in    = OFF_W'(1);
            end else if (volt_ff <= CURVE_MV[CURVE_POINTS - 1]) begin
               lo_pct_in = PCT_EMPTY;
               quo_in    = '0;
               div_in    = OFF_W'(1);
            end else begin
               lo_pct_in = CURVE_PCT[seg_lo_idx];
               quo_in    = product;
               div_in    = span_mv;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = trial_ge ? OFF_W'(trial - {1'b0, div_ff}) : trial[OFF_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], trial_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               pct_in       = lo_pct_ff + quo_in[PCT_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_accept) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         notify_thr_ff <= NOTIFY_THR_RESET;
         charge_thr_ff <= CHARGE_THR_RESET;
         prev_mv_ff    <= '0;
         primed_ff     <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         notify_thr_ff <= notify_thr_in;
         charge_thr_ff <= charge_thr_in;
         prev_mv_ff    <= prev_mv_in;
         primed_ff     <= primed_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         volt_ff       <= volt_in;
         notify_ff     <= notify_in;
         charging_ff   <= charging_in;
         lo_pct_ff     <= lo_pct_in;
         quo_ff        <= quo_in;
         rem_ff        <= rem_in;
         div_ff        <= div_in;
         pct_ff        <= pct_in;
      end
   end

`include "battery_voltage_to_charge_percent_top_assert.svh"

   `BVCP_ASSERT_SAME(a_busy_while_responding, rsp_valid_ff, !req_ready,
                     "request accepted while a response is pending")
   `BVCP_ASSERT_SAME(a_pct_in_range, rsp_valid_ff, pct_ff <= PCT_FULL,
                     "charge percent above full scale")
   `BVCP_ASSERT_NEXT(a_accept_starts_setup, req_accept,
                     (state_ff == ST_SETUP) && !rsp_valid_ff,
                     "accepted request did not enter segment setup")
   `BVCP_ASSERT_SAME(a_div_count_bound, state_ff == ST_DIV, cnt_ff <= LAST_STEP,
                     "divider step count overran")
   `BVCP_ASSERT_SAME(a_primed_on_response, rsp_valid_ff, primed_ff,
                     "response without a stored previous voltage")

endmodule

`default_nettype wire
